>>> rtl/dpvs_pkg.sv
// Shared types, codes and constants of the converter power-up and volume sequencer.
package dpvs_pkg;

	// Command codes carried in the input tuser
	localparam logic [2:0] MODE_TICK   = 3'd0;
	localparam logic [2:0] MODE_START  = 3'd1;
	localparam logic [2:0] MODE_MUTE   = 3'd2;
	localparam logic [2:0] MODE_VOLUME = 3'd3;
	localparam logic [2:0] MODE_FORMAT = 3'd4;

	// Transfer kinds
	localparam logic [1:0] KIND_NONE      = 2'd0;
	localparam logic [1:0] KIND_REGISTER  = 2'd1;
	localparam logic [1:0] KIND_BOOTSTRAP = 2'd2;

	// Converter register selects
	localparam logic [1:0] REG_MUTE    = 2'd0;
	localparam logic [1:0] REG_LEFT    = 2'd1;
	localparam logic [1:0] REG_RIGHT   = 2'd2;
	localparam logic [1:0] REG_CONTROL = 2'd3;

	// Register data bytes
	localparam logic [7:0] MUTE_ON_VALUE  = 8'hD8;
	localparam logic [7:0] MUTE_OFF_VALUE = 8'hC0;
	localparam logic [7:0] CONTROL_VALUE  = 8'hB0;

	// Configuration register indexes
	localparam logic [2:0] CFG_RESET_ASSERT  = 3'd0;
	localparam logic [2:0] CFG_RESET_RELEASE = 3'd1;
	localparam logic [2:0] CFG_SELECT_SETUP  = 3'd2;
	localparam logic [2:0] CFG_BETWEEN       = 3'd3;
	localparam logic [2:0] CFG_COUNT         = 3'd4;

	// Volume: floor of -127.5 dB in Q8.8, half-dB steps of 128 LSBs
	localparam logic signed [15:0] VOL_FLOOR  = -16'sh7F80;
	localparam int                 STEP_Q8    = 128;
	localparam int                 STEP_SHIFT = $clog2(STEP_Q8);
	localparam logic [15:0]        STEP_HALF  = 16'(STEP_Q8 / 2);

	// Phase codes as shown on the result
	localparam logic [2:0] PH_CODE_IDLE     = 3'd0;
	localparam logic [2:0] PH_CODE_WRESET   = 3'd1;
	localparam logic [2:0] PH_CODE_WRELEASE = 3'd2;
	localparam logic [2:0] PH_CODE_WSELECT  = 3'd3;
	localparam logic [2:0] PH_CODE_WBETWEEN = 3'd4;
	localparam logic [2:0] PH_CODE_READY    = 3'd5;
	localparam logic [2:0] PH_CODE_FAULT    = 3'd6;

	// Result queue depth
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [6:0] {
		PH_IDLE     = 7'b0000001,
		PH_WRESET   = 7'b0000010,
		PH_WRELEASE = 7'b0000100,
		PH_WSELECT  = 7'b0001000,
		PH_WBETWEEN = 7'b0010000,
		PH_READY    = 7'b0100000,
		PH_FAULT    = 7'b1000000
	} phase_t;

	// One executed command, waiting to be shown as one or two result items
	typedef struct packed {
		logic       acc;
		logic [1:0] kind;
		logic [1:0] rsel;
		logic [7:0] rval;
		logic [3:0] idx;
		logic       rst;
		logic       sel;
		logic       muted;
		logic [2:0] phase_code;
		logic       two;
	} job_t;

	function automatic logic [2:0] phase_to_code(input phase_t ph);
		logic [2:0] code;
		case (ph)
			PH_IDLE:     code = PH_CODE_IDLE;
			PH_WRESET:   code = PH_CODE_WRESET;
			PH_WRELEASE: code = PH_CODE_WRELEASE;
			PH_WSELECT:  code = PH_CODE_WSELECT;
			PH_WBETWEEN: code = PH_CODE_WBETWEEN;
			PH_READY:    code = PH_CODE_READY;
			PH_FAULT:    code = PH_CODE_FAULT;
			default:     code = PH_CODE_IDLE;
		endcase
		return code;
	endfunction

endpackage

>>> rtl/dac_powerup_and_volume_sequencer.sv
// Top level of the converter power-up and volume sequencer.
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: mode; tdata: time, mute, volume, format, bus ok
// m_*       out  m_tvalid/m_tready  tuser: write kind; tdata: status and write; tlast
// cfg_*     in   cfg_we             cfg_index, cfg_data
//
// One input item is accepted per cycle while the four-entry queue has room;
// each executes in the cycle it is accepted. Results leave one per cycle from
// the output register while m_tready is high, so a volume command (two results)
// holds the output for both of its items in turn. Reset is asynchronous and
// active low and needs no clearing pass. Output stalls fill the queue and then hold s_tready low.
module dac_powerup_and_volume_sequencer import dpvs_pkg::*; #(
	parameter int MAX_BOOTSTRAP = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// bits: now_time[31:0], mute_request[32], volume_db_q8[48:33],
	// format_selector[56:49], bus_ok[57], zero fill [63:58]
	input  logic [63:0] s_tdata,
	// bits: mode[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// bits: accepted[0], register_select[2:1], register_value[10:3],
	// bootstrap_index[14:11], reset_line[15], select_line[16], muted_flag[17],
	// fault_flag[18], phase_code[21:19], zero fill [23:22]
	output logic [23:0] m_tdata,
	// bits: write_kind[1:0]
	output logic [1:0]  m_tuser,
	output logic        m_tlast
);

	logic take, full, pop, nonempty;
	job_t job, head;

	assign s_tready = !full;
	assign take     = s_tvalid && s_tready;

	dpvs_front #(
		.MAX_BOOTSTRAP(MAX_BOOTSTRAP)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.take           (take),
		.mode           (s_tuser),
		.now_time       (s_tdata[31:0]),
		.mute_request   (s_tdata[32]),
		.volume_db_q8   (s_tdata[48:33]),
		.format_selector(s_tdata[56:49]),
		.bus_ok         (s_tdata[57]),
		.job            (job)
	);

	dpvs_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (take),
		.push_job(job),
		.full    (full),
		.pop     (pop),
		.nonempty(nonempty),
		.head    (head)
	);

	dpvs_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.nonempty(nonempty),
		.head    (head),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule

>>> rtl/dpvs_front.sv
// Front end: configuration registers, sequencer state and per-command execution.
module dpvs_front import dpvs_pkg::*; #(
	parameter int MAX_BOOTSTRAP = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        take,
	input  logic [2:0]  mode,
	input  logic [31:0] now_time,
	input  logic        mute_request,
	input  logic [15:0] volume_db_q8,
	input  logic [7:0]  format_selector,
	input  logic        bus_ok,
	output job_t        job
);

	logic [15:0] assert_time_q, release_time_q, setup_time_q, between_time_q;
	logic [4:0]  count_q;

	phase_t      phase_q, nphase;
	logic [31:0] deadline_q, ndead;
	logic [4:0]  pos_q, npos;
	logic        muted_q, nmuted, reset_q, nrst, select_q, nsel;

	logic [31:0]        diff;
	logic               reached;
	logic [4:0]         cnt_eff;
	logic [4:0]         pos_inc;
	logic signed [15:0] vol, vclamp;
	logic [15:0]        mag, mag_rnd;
	logic [7:0]         vol_val;

	logic       acc, two;
	logic [1:0] kind, rsel;
	logic [7:0] rval;
	logic [3:0] idx;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			assert_time_q  <= 16'd1;
			release_time_q <= 16'd1;
			setup_time_q   <= 16'd0;
			between_time_q <= 16'd0;
			count_q        <= 5'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RESET_ASSERT:  assert_time_q  <= cfg_data;
				CFG_RESET_RELEASE: release_time_q <= cfg_data;
				CFG_SELECT_SETUP:  setup_time_q   <= cfg_data;
				CFG_BETWEEN:       between_time_q <= cfg_data;
				CFG_COUNT:         count_q        <= cfg_data[4:0];
				default:           ;
			endcase
		end
	end

	// Wrap-safe deadline test and bootstrap count limits
	assign diff    = now_time - deadline_q;
	assign reached = !diff[31];
	always_comb begin
		if (count_q == 5'd0)
			cnt_eff = 5'd1;
		else if (32'(count_q) > MAX_BOOTSTRAP)
			cnt_eff = 5'(MAX_BOOTSTRAP);
		else
			cnt_eff = count_q;
	end
	assign pos_inc = pos_q + 5'd1;

	// Clamp volume to 0 .. -127.5 dB and round to half-dB attenuation steps
	assign vol = volume_db_q8;
	always_comb begin
		if (vol > 16'sd0)
			vclamp = 16'sd0;
		else if (vol < VOL_FLOOR)
			vclamp = VOL_FLOOR;
		else
			vclamp = vol;
	end
	assign mag     = 16'(-vclamp);
	assign mag_rnd = mag + STEP_HALF;
	assign vol_val = mag_rnd[STEP_SHIFT +: 8];

	// Execute one command against the current state
	always_comb begin
		nphase = phase_q;
		ndead  = deadline_q;
		npos   = pos_q;
		nmuted = muted_q;
		nrst   = reset_q;
		nsel   = select_q;
		acc    = 1'b0;
		two    = 1'b0;
		kind   = KIND_NONE;
		rsel   = REG_MUTE;
		rval   = 8'd0;
		idx    = 4'd0;
		case (mode)
			MODE_TICK: begin
				if (reached) begin
					case (phase_q)
						PH_WRESET: begin
							nrst   = 1'b0;
							ndead  = now_time + 32'(release_time_q);
							nphase = PH_WRELEASE;
							acc    = 1'b1;
						end
						PH_WRELEASE, PH_WBETWEEN: begin
							nsel   = 1'b1;
							ndead  = now_time + 32'(setup_time_q);
							nphase = PH_WSELECT;
							acc    = 1'b1;
						end
						PH_WSELECT: begin
							nsel = 1'b0;
							if (pos_q >= cnt_eff) begin
								nphase = PH_READY;
								acc    = 1'b1;
							end else begin
								kind = KIND_BOOTSTRAP;
								idx  = pos_q[3:0];
								if (!bus_ok) begin
									nrst   = 1'b1;
									nphase = PH_FAULT;
								end else begin
									npos = pos_inc;
									acc  = 1'b1;
									if (pos_inc >= cnt_eff) begin
										nphase = PH_READY;
									end else begin
										ndead  = now_time + 32'(between_time_q);
										nphase = PH_WBETWEEN;
									end
								end
							end
						end
						default: ;
					endcase
				end
			end
			MODE_START: begin
				nsel   = 1'b0;
				nrst   = 1'b1;
				npos   = 5'd0;
				nmuted = 1'b1;
				ndead  = now_time + 32'(assert_time_q);
				nphase = PH_WRESET;
				acc    = 1'b1;
			end
			MODE_MUTE, MODE_VOLUME, MODE_FORMAT: begin
				if (phase_q == PH_READY &&
				    (mode != MODE_FORMAT || format_selector == 8'd0)) begin
					kind = KIND_REGISTER;
					nsel = 1'b0;
					if (mode == MODE_MUTE) begin
						rsel = REG_MUTE;
						rval = mute_request ? MUTE_ON_VALUE : MUTE_OFF_VALUE;
					end else if (mode == MODE_VOLUME) begin
						rsel = REG_LEFT;
						rval = vol_val;
						two  = 1'b1;
					end else begin
						rsel = REG_CONTROL;
						rval = CONTROL_VALUE;
					end
					if (!bus_ok) begin
						nrst   = 1'b1;
						nmuted = 1'b1;
						nphase = PH_FAULT;
					end else begin
						acc = 1'b1;
						if (mode == MODE_MUTE)
							nmuted = mute_request;
					end
				end
			end
			default: ;
		endcase
	end

	// Advance state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			deadline_q <= 32'd0;
			pos_q      <= 5'd0;
			muted_q    <= 1'b1;
			reset_q    <= 1'b0;
			select_q   <= 1'b0;
		end else if (take) begin
			phase_q    <= nphase;
			deadline_q <= ndead;
			pos_q      <= npos;
			muted_q    <= nmuted;
			reset_q    <= nrst;
			select_q   <= nsel;
		end
	end

	// Hand the executed command to the queue with the state after it
	always_comb begin
		job.acc        = acc;
		job.kind       = kind;
		job.rsel       = rsel;
		job.rval       = rval;
		job.idx        = idx;
		job.rst        = nrst;
		job.sel        = nsel;
		job.muted      = nmuted;
		job.phase_code = phase_to_code(nphase);
		job.two        = two;
	end

`ifndef SYNTHESIS
	a_fault_holds_reset: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_FAULT |-> reset_q)
		else $error("fault phase without reset asserted");
	a_ready_released: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_READY |-> !reset_q && !select_q)
		else $error("ready phase with reset or select asserted");
	a_select_in_setup: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_WSELECT |-> select_q)
		else $error("select setup wait without select asserted");
`endif

endmodule

>>> rtl/dpvs_queue.sv
// Short queue of executed commands between the front and back ends.
module dpvs_queue import dpvs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic nonempty,
	output job_t head
);

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full     = cnt_q == QCNT_W'(QDEPTH);
	assign nonempty = cnt_q != '0;
	assign head     = mem_q[rd_ptr_q];

	// Store the pushed item
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

`ifndef SYNTHESIS
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop |-> !full) and (pop |-> nonempty))
		else $error("queue overrun or underrun");
`endif

endmodule

>>> rtl/dpvs_back.sv
// Back end: expands queued commands into result items behind an output register.
module dpvs_back import dpvs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        nonempty,
	input  job_t        head,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,
	output logic [1:0]  m_tuser,
	output logic        m_tlast
);

	logic        m_tvalid_q, half_q;
	logic [23:0] m_tdata_q;
	logic [1:0]  m_tuser_q;
	logic        m_tlast_q;
	logic        load, second;
	logic [1:0]  rsel;

	// Load when the output register is free or being drained
	assign load   = nonempty && (!m_tvalid_q || m_tready);
	assign second = head.two && half_q;
	assign pop    = load && !(head.two && !half_q);
	assign rsel   = second ? REG_RIGHT : head.rsel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			half_q     <= 1'b0;
		end else begin
			if (load) begin
				m_tvalid_q <= 1'b1;
				half_q     <= head.two && !half_q;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Pack the result item
	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata_q <= {2'b00, head.phase_code, head.phase_code == PH_CODE_FAULT,
			              head.muted, head.sel, head.rst, head.idx, head.rval, rsel,
			              head.acc};
			m_tuser_q <= head.kind;
			m_tlast_q <= !(head.two && !half_q);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

`ifndef SYNTHESIS
	a_pair_shown: assert property (@(posedge clk) disable iff (!arst_n)
		half_q |-> m_tvalid_q && !m_tlast_q)
		else $error("second half pending without first half shown");
`endif

endmodule
